### design/ctsch_pkg.sv
// ----------------------------------------------------------------------------
// ctsch_pkg
// Types and constants shared by the cooperative task scheduler and its testbench.
// ----------------------------------------------------------------------------
package ctsch_pkg;

  localparam int NUM_SLOTS      = 8;
  localparam int TICK_PERIOD_MS = 10;
  localparam int SLOT_W         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W          = SLOT_W + 1;
  localparam int TICKS_W        = 28;
  localparam int RESULT_CAP     = 8;

  localparam logic [31:0] TICKS_MAX        = 32'h0FFF_FFFF;
  localparam logic [15:0] WDOG_RESET_LIMIT = 16'd300;
  // floor((2^32 - 1) / tick period), reciprocal for the ms to tick conversion
  localparam logic [31:0] RECIP = 32'(((64'd1 << 32) - 64'd1) / 64'(TICK_PERIOD_MS));

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_TICK     = 3'd2,
    ACT_DISPATCH = 3'd3,
    ACT_CLEAR_WD = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NEG   = 2'd2,
    STAT_NODEL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_PROC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  task_handle;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [7:0]  slot_to_delete;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [7:0]  run_handle;
    logic        run_valid;
    logic [15:0] task_number;
    logic [1:0]  last_error;
    logic        watchdog_expired;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         handle;
    logic [TICKS_W-1:0] delay;
    logic [TICKS_W-1:0] period;
    logic [7:0]         pending;
    logic [15:0]        number;
  } entry_t;

endpackage

### design/cooperative_task_scheduler.sv
// ----------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered cooperative scheduler with its slot table in one RAM.
// ----------------------------------------------------------------------------
// An add passes ST_MUL and ST_FIX (two-step ms to tick conversion) before
//   ST_RESP; delete, clear and unknown actions go straight to ST_RESP.
// Tick and dispatch walk the slot RAM one slot per cycle; a dispatch stalls on
//   a due slot while the output is full, ends at its last due slot or result cap.
// One item is in work at a time; the next one is accepted once the block is idle.
// Reset is asynchronous, clears control state and slot valid bits; the RAM
//   needs no clearing pass.
module cooperative_task_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ctsch_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ctsch_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import ctsch_pkg::*;

  state_e              state_q, state_d;
  in_item_t            in_q;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]    cursor_q, cursor_d;
  logic [3:0]          nres_q, nres_d;
  logic [15:0]         next_num_q, next_num_d;
  logic [31:0]         wd_q, wd_d;
  logic [1:0]          err_q, err_d;
  logic [15:0]         limit_q;
  logic [62:0]         prod_dly_q, prod_per_q;
  out_item_t           resp_q, resp_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;

  // slot control signals
  logic                out_free;
  logic                accept;
  logic [SLOT_W-1:0]   cur_slot;
  logic                last_slot;
  logic                disp_hit;
  logic                higher_pend;
  logic                disp_last;
  logic                wd_exp;
  logic                tbl_full;
  logic [SLOT_W-1:0]   free_slot;
  logic                out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign wd_exp      = (wd_q > {16'd0, limit_q});

  ctsch_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cursor_d[SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // quotient fix-up: q0 is the true quotient or one below it
  function automatic logic [TICKS_W-1:0] fix_ticks(logic [30:0] x, logic [30:0] q0);
    logic [31:0] r;
    logic [31:0] q;
    r = {1'b0, x} - (32'(q0) * 32'(TICK_PERIOD_MS));
    q = 32'(q0) + ((r >= 32'(TICK_PERIOD_MS)) ? 32'd1 : 32'd0);
    return (q > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : q[TICKS_W-1:0];
  endfunction

  // slot decisions
  always_comb begin
    cur_slot    = cursor_q[SLOT_W-1:0];
    last_slot   = (cursor_q == CNT_W'(NUM_SLOTS - 1));
    disp_hit    = used_q[cur_slot] && pend_q[cur_slot];
    higher_pend = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (j > int'(cur_slot) && pend_q[j]) begin
        higher_pend = 1'b1;
      end
    end
    disp_last = (nres_q == 4'(RESULT_CAP - 1)) || !higher_pend;
    tbl_full  = &used_q;
    free_slot = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!used_q[j]) begin
        free_slot = SLOT_W'(j);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.action)
            ACT_ADD:      state_d = ST_MUL;
            ACT_TICK:     state_d = ST_PROC;
            ACT_DISPATCH: state_d = (|pend_q) ? ST_PROC : ST_RESP;
            default:      state_d = ST_RESP;
          endcase
        end
      end
      ST_MUL:  state_d = ST_FIX;
      ST_FIX:  state_d = ST_RESP;
      ST_PROC: begin
        if (in_q.action == ACT_TICK) begin
          if (last_slot) state_d = ST_RESP;
        end else if (disp_hit) begin
          if (out_free && disp_last) state_d = ST_IDLE;
        end else if (last_slot) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    entry_t e;
    logic [7:0] pnew;
    e           = ram_rdata;
    pnew        = '0;
    used_d      = used_q;
    pend_d      = pend_q;
    cursor_d    = cursor_q;
    nres_d      = nres_q;
    next_num_d  = next_num_q;
    wd_d        = wd_q;
    err_d       = err_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_slot;
    ram_wdata   = ram_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          resp_d   = '0;
          cursor_d = '0;
          nres_d   = '0;
          case (in_item_i.action)
            ACT_DELETE: begin
              if ({1'b0, in_item_i.slot_to_delete} >= 9'(NUM_SLOTS)) begin
                resp_d.status = STAT_NODEL;
                err_d         = STAT_NODEL;
              end else begin
                if (!used_q[in_item_i.slot_to_delete[SLOT_W-1:0]]) begin
                  resp_d.status = STAT_NODEL;
                  err_d         = STAT_NODEL;
                end
                used_d[in_item_i.slot_to_delete[SLOT_W-1:0]] = 1'b0;
                pend_d[in_item_i.slot_to_delete[SLOT_W-1:0]] = 1'b0;
              end
            end
            ACT_TICK:     wd_d = wd_q + 32'd1;
            ACT_CLEAR_WD: wd_d = '0;
            default: ;
          endcase
        end
      end
      ST_FIX: begin
        if (tbl_full) begin
          err_d             = STAT_FULL;
          resp_d.status     = STAT_FULL;
          resp_d.slot_index = 4'(NUM_SLOTS);
        end else if (in_q.delay_ms[31] || in_q.period_ms[31]) begin
          err_d         = STAT_NEG;
          resp_d.status = STAT_NEG;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = free_slot;
          ram_wdata.handle  = in_q.task_handle;
          ram_wdata.delay   = fix_ticks(in_q.delay_ms[30:0], prod_dly_q[62:32]);
          ram_wdata.period  = fix_ticks(in_q.period_ms[30:0], prod_per_q[62:32]);
          ram_wdata.pending = '0;
          ram_wdata.number  = next_num_q;
          used_d[free_slot] = 1'b1;
          pend_d[free_slot] = 1'b0;
          next_num_d        = next_num_q + 16'd1;
          resp_d.slot_index = 4'(free_slot);
          resp_d.task_number = next_num_q;
        end
      end
      ST_PROC: begin
        if (in_q.action == ACT_TICK) begin
          // count down, mark due slots
          if (used_q[cur_slot]) begin
            ram_we = 1'b1;
            if (e.delay == '0) begin
              ram_wdata.pending = (e.pending == 8'hFF) ? e.pending : e.pending + 8'd1;
              if (e.period != '0) ram_wdata.delay = e.period - TICKS_W'(1);
              pend_d[cur_slot] = 1'b1;
            end else begin
              ram_wdata.delay = e.delay - TICKS_W'(1);
            end
          end
          if (!last_slot) cursor_d = cursor_q + CNT_W'(1);
        end else if (disp_hit) begin
          // emit one due slot when the output register frees up
          if (out_free) begin
            pnew              = e.pending - 8'd1;
            ram_we            = 1'b1;
            ram_wdata.pending = pnew;
            if (e.period == '0) begin
              used_d[cur_slot] = 1'b0;
              pend_d[cur_slot] = 1'b0;
            end else begin
              pend_d[cur_slot] = (pnew != 8'd0);
            end
            out_load               = 1'b1;
            out_d.status           = STAT_OK;
            out_d.slot_index       = 4'(cur_slot);
            out_d.run_handle       = e.handle;
            out_d.run_valid        = 1'b1;
            out_d.task_number      = e.number;
            out_d.last_error       = err_q;
            out_d.watchdog_expired = wd_exp;
            out_d.last             = disp_last;
            nres_d                 = nres_q + 4'd1;
            if (!last_slot) cursor_d = cursor_q + CNT_W'(1);
          end
        end else if (!last_slot) begin
          cursor_d = cursor_q + CNT_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_d                  = resp_q;
          out_d.last_error       = err_q;
          out_d.watchdog_expired = wd_exp;
          out_d.last             = 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      pend_q      <= '0;
      cursor_q    <= '0;
      nres_q      <= '0;
      next_num_q  <= '0;
      wd_q        <= '0;
      err_q       <= '0;
      limit_q     <= WDOG_RESET_LIMIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      cursor_q    <= cursor_d;
      nres_q      <= nres_d;
      next_num_q  <= next_num_d;
      wd_q        <= wd_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (state_q == ST_MUL) begin
      prod_dly_q <= 63'(in_q.delay_ms[30:0]) * 63'(RECIP);
      prod_per_q <= 63'(in_q.period_ms[30:0]) * 63'(RECIP);
    end
    resp_q <= resp_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  // a due slot is always an occupied slot
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pend_q & ~used_q) == '0)
    else $error("pending flag on a free slot");

  // the slot walk never leaves the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROC |-> cursor_q < CNT_W'(NUM_SLOTS))
    else $error("slot cursor out of range");

  // an add writes the slot and marks it occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == ST_FIX) |=> used_q[$past(ram_waddr)])
    else $error("added slot not marked used");

  // the final dispatch result ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == ST_PROC && out_d.last) |=> state_q == ST_IDLE)
    else $error("dispatch continued past its last result");
`endif

endmodule

### design/ctsch_ram.sv
// ----------------------------------------------------------------------------
// ctsch_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ctsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### test/tb_cooperative_task_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cooperative_task_scheduler
// Drives add, delete, tick, dispatch, watchdog-clear and unknown-action items into the
// scheduler with random idling and back-pressure, predicts every result with
// a local table model and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler;
  import ctsch_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  N_RANDOM     = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  cooperative_task_scheduler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler shadow state
  logic        m_used    [NUM_SLOTS];
  logic [7:0]  m_handle  [NUM_SLOTS];
  logic [31:0] m_delay   [NUM_SLOTS];
  logic [31:0] m_period  [NUM_SLOTS];
  logic [7:0]  m_pending [NUM_SLOTS];
  logic [15:0] m_number  [NUM_SLOTS];
  logic [15:0] m_next_num;
  logic [31:0] m_wd_ticks;
  logic [1:0]  m_err;
  logic [15:0] m_wd_limit;

  out_item_t   sched_results_q[$];
  int          n_errors = 0;
  int          cycle_cnt = 0;
  bit          quiet_rx = 1'b0;
  bit          hold_rx = 1'b0;
  bit          hold_go = 1'b0;
  bit          busy_mode = 1'b1;

  function automatic logic [31:0] ms_to_ticks(logic [31:0] ms);
    logic [31:0] t;
    t = ms / TICK_PERIOD_MS;
    return (t > TICKS_MAX) ? TICKS_MAX : t;
  endfunction

  function automatic void clear_slot(int i);
    m_used[i] = 1'b0;
    m_delay[i] = '0;
    m_period[i] = '0;
    m_pending[i] = '0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [3:0] slot, logic [7:0] h,
                                      logic v, logic [15:0] num);
    out_item_t r;
    r.status = st;
    r.slot_index = slot;
    r.run_handle = h;
    r.run_valid = v;
    r.task_number = num;
    r.last_error = m_err;
    r.watchdog_expired = (m_wd_ticks > {16'd0, m_wd_limit});
    r.last = 1'b0;
    sched_results_q.push_back(r);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      clear_slot(i);
      m_handle[i] = '0;
      m_number[i] = '0;
    end
    m_next_num = '0;
    m_wd_ticks = '0;
    m_err = STAT_OK;
    m_wd_limit = WDOG_RESET_LIMIT;
  endfunction

  // predict the results of one accepted item
  function automatic void schedule_predict(in_item_t it);
    int i;
    int n;
    out_item_t r;
    n = 0;
    case (it.action)
      ACT_ADD: begin
        for (i = 0; i < NUM_SLOTS && m_used[i]; i++) ;
        if (i == NUM_SLOTS) begin
          m_err = STAT_FULL;
          push_result(STAT_FULL, 4'(NUM_SLOTS), '0, 1'b0, '0);
        end else if (it.delay_ms[31] | it.period_ms[31]) begin
          m_err = STAT_NEG;
          push_result(STAT_NEG, '0, '0, 1'b0, '0);
        end else begin
          m_used[i] = 1'b1;
          m_handle[i] = it.task_handle;
          m_delay[i] = ms_to_ticks(it.delay_ms);
          m_period[i] = ms_to_ticks(it.period_ms);
          m_pending[i] = '0;
          m_number[i] = m_next_num;
          m_next_num = m_next_num + 16'd1;
          push_result(STAT_OK, 4'(i), '0, 1'b0, m_number[i]);
        end
      end
      ACT_DELETE: begin
        logic [1:0] st;
        st = STAT_OK;
        if (it.slot_to_delete >= NUM_SLOTS) begin
          st = STAT_NODEL;
          m_err = STAT_NODEL;
        end else begin
          if (!m_used[it.slot_to_delete[SLOT_W-1:0]]) begin
            st = STAT_NODEL;
            m_err = STAT_NODEL;
          end
          clear_slot(int'(it.slot_to_delete));
        end
        push_result(st, '0, '0, 1'b0, '0);
      end
      ACT_TICK: begin
        m_wd_ticks = m_wd_ticks + 32'd1;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (m_used[i]) begin
            if (m_delay[i] == 0) begin
              if (m_pending[i] != 8'hFF) m_pending[i] = m_pending[i] + 8'd1;
              if (m_period[i] != 0) m_delay[i] = m_period[i] - 32'd1;
            end else begin
              m_delay[i] = m_delay[i] - 32'd1;
            end
          end
        end
        push_result(STAT_OK, '0, '0, 1'b0, '0);
      end
      ACT_DISPATCH: begin
        for (i = 0; i < NUM_SLOTS && n < RESULT_CAP; i++) begin
          if (m_used[i] && m_pending[i] != 0) begin
            logic [7:0]  h;
            logic [15:0] num;
            m_pending[i] = m_pending[i] - 8'd1;
            h = m_handle[i];
            num = m_number[i];
            if (m_period[i] == 0) clear_slot(i);
            push_result(STAT_OK, 4'(i), h, 1'b1, num);
            n++;
          end
        end
        if (n == 0) push_result(STAT_OK, '0, '0, 1'b0, '0);
      end
      ACT_CLEAR_WD: begin
        m_wd_ticks = '0;
        push_result(STAT_OK, '0, '0, 1'b0, '0);
      end
      default: push_result(STAT_OK, '0, '0, 1'b0, '0);
    endcase
    r = sched_results_q.pop_back();
    r.last = 1'b1;
    sched_results_q.push_back(r);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL cooperative_task_scheduler");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_results_q.size() == 0) begin
        $error("result with nothing expected: %p", out_item_o);
        n_errors++;
      end else begin
        out_item_t e;
        e = sched_results_q.pop_front();
        if (out_item_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item_o.status); n_errors++;
        end
        if (out_item_o.slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, out_item_o.slot_index);
          n_errors++;
        end
        if (out_item_o.run_handle !== e.run_handle) begin
          $error("run_handle exp %0d got %0d", e.run_handle, out_item_o.run_handle);
          n_errors++;
        end
        if (out_item_o.run_valid !== e.run_valid) begin
          $error("run_valid exp %0d got %0d", e.run_valid, out_item_o.run_valid);
          n_errors++;
        end
        if (out_item_o.task_number !== e.task_number) begin
          $error("task_number exp %0d got %0d", e.task_number, out_item_o.task_number);
          n_errors++;
        end
        if (out_item_o.last_error !== e.last_error) begin
          $error("last_error exp %0d got %0d", e.last_error, out_item_o.last_error);
          n_errors++;
        end
        if (out_item_o.watchdog_expired !== e.watchdog_expired) begin
          $error("watchdog_expired exp %0d got %0d", e.watchdog_expired,
                 out_item_o.watchdog_expired);
          n_errors++;
        end
        if (out_item_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item_o.last); n_errors++;
        end
      end
    end
  end

  // receiver: random stalls, a quiet stretch, and a long hold-off
  always @(negedge clk_i) begin
    if (hold_rx) out_ready_i <= 1'b0;
    else if (quiet_rx) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 12);
  end

  initial begin : rx_hold
    wait (hold_go);
    @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // send one item, with an optional random gap first
  task automatic send_item(in_item_t it);
    if (!busy_mode) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    schedule_predict(it);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sched_results_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_wd_limit = v;
  endtask

  function automatic in_item_t mk(logic [2:0] a, logic [7:0] h, logic [31:0] d,
                                  logic [31:0] p, logic [7:0] s);
    in_item_t it;
    it.action = a;
    it.task_handle = h;
    it.delay_ms = d;
    it.period_ms = p;
    it.slot_to_delete = s;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = mk(ACT_TICK, 8'($urandom), $urandom, $urandom, 8'($urandom));
    if (sel < 25) begin
      it.action = ACT_ADD;
      // mostly small, well-formed times
      if ($urandom_range(9) < 8) begin
        it.delay_ms = $urandom_range(60);
        it.period_ms = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
      end
    end else if (sel < 35) begin
      it.action = ACT_DELETE;
      if ($urandom_range(3) != 0) it.slot_to_delete = 8'($urandom_range(NUM_SLOTS - 1));
    end else if (sel < 65) it.action = ACT_TICK;
    else if (sel < 88) it.action = ACT_DISPATCH;
    else if (sel < 95) it.action = ACT_CLEAR_WD;
    else it.action = 3'($urandom_range(7, 5));
    return it;
  endfunction

  // directed rows; expected result given only where fixed by reset state
  typedef struct {
    in_item_t  it;
    bit        has_exp;
    out_item_t exp;
  } dir_row_t;

  initial begin : stim
    dir_row_t rows[$];
    dir_row_t row;
    out_item_t got;
    rst_ni = 1'b0;
    model_reset();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    row.has_exp = 1'b1;
    row.it = mk(ACT_DISPATCH, 0, 0, 0, 0);
    row.exp = '{STAT_OK, 4'd0, 8'd0, 1'b0, 16'd0, STAT_OK, 1'b0, 1'b1};
    rows.push_back(row);
    row.it = mk(ACT_DELETE, 0, 0, 0, 8'hFF);
    row.exp = '{STAT_NODEL, 4'd0, 8'd0, 1'b0, 16'd0, STAT_NODEL, 1'b0, 1'b1};
    rows.push_back(row);
    row.it = mk(ACT_ADD, 8'hAA, 32'h8000_0000, 0, 0);
    row.exp = '{STAT_NEG, 4'd0, 8'd0, 1'b0, 16'd0, STAT_NEG, 1'b0, 1'b1};
    rows.push_back(row);
    row.it = mk(ACT_ADD, 8'hFF, 0, 0, 0);
    row.exp = '{STAT_OK, 4'd0, 8'd0, 1'b0, 16'd0, STAT_NEG, 1'b0, 1'b1};
    rows.push_back(row);
    row.has_exp = 1'b0;
    rows.push_back('{mk(ACT_ADD, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_ADD, 8'h55, 0, 32'hFFFF_FFFF, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_ADD, 8'h11, 9, 25, 0), 1'b0, '0});
    for (int k = 0; k < 5; k++)
      rows.push_back('{mk(ACT_ADD, 8'(k + 1), 10 * k, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_ADD, 8'h77, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_DELETE, 0, 0, 0, 8'd7), 1'b0, '0});
    rows.push_back('{mk(ACT_DELETE, 0, 0, 0, 8'd7), 1'b0, '0});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_DISPATCH, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(ACT_CLEAR_WD, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 1'b0, '0});
    rows.push_back('{mk(3'd5, 0, 0, 0, 0), 1'b0, '0});

    foreach (rows[k]) begin
      send_item(rows[k].it);
      if (rows[k].has_exp) begin
        got = sched_results_q[sched_results_q.size() - 1];
        if (got !== rows[k].exp) begin
          $error("directed row %0d: expected %p, predictor %p", k, rows[k].exp, got);
          n_errors++;
        end
      end
    end
    wait_idle();

    // random phases under several watchdog limits
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(16'd0);
        1: write_limit(16'hFFFF);
        2: write_limit(16'($urandom_range(2, 40)));
        default: write_limit(WDOG_RESET_LIMIT);
      endcase
      busy_mode = (ph == 0);
      quiet_rx = (ph == 0);
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        // long receiver hold-off while items keep coming
        if (ph == 1 && k == 5) hold_go = 1'b1;
        send_item(rand_item());
        // sender pause until everything has drained
        if (ph == 2 && k == 20) wait_idle();
      end
      wait_idle();
    end
    quiet_rx = 1'b0;

    if (n_errors == 0) begin
      $display("PASS cooperative_task_scheduler");
    end else begin
      $display("FAIL cooperative_task_scheduler");
    end
    $finish;
  end

endmodule

### files.f
design/ctsch_pkg.sv
design/ctsch_ram.sv
design/cooperative_task_scheduler.sv
test/tb_cooperative_task_scheduler.sv
